>>> design/b2s_pkg.sv
// Shared constants, register index codes and config clamp helpers for the
// batch-to-space address map. No dependencies.
package b2s_pkg;

  localparam int B2S_SRC_BATCH_W  = 16;
  localparam int B2S_SRC_ROW_W    = 12;
  localparam int B2S_SRC_COL_W    = 12;
  localparam int B2S_DST_BATCH_W  = 8;
  localparam int B2S_DST_ROW_W    = 12;
  localparam int B2S_DST_COL_W    = 12;
  localparam int B2S_OFFSET_W     = 44;
  localparam int B2S_CFG_IDX_W    = 3;
  localparam int B2S_CFG_DATA_W   = 13;
  localparam int B2S_NB_W         = 9;   // out_batches, 1..256
  localparam int B2S_DIM_W        = 13;  // height, width, channels, 0..4096
  localparam int B2S_BLK_W        = 5;   // block sizes, 1..16
  localparam int B2S_CROP_W       = 8;
  localparam int B2S_NBBC_W       = 13;  // out_batches * block_cols, up to 4096
  localparam int B2S_DIV_STAGES   = 4;   // must divide B2S_SRC_BATCH_W

  typedef enum logic [B2S_CFG_IDX_W-1:0] {
    CFG_OUT_BATCHES = 3'd0,
    CFG_OUT_HEIGHT  = 3'd1,
    CFG_OUT_WIDTH   = 3'd2,
    CFG_CHANNELS    = 3'd3,
    CFG_BLOCK_ROWS  = 3'd4,
    CFG_BLOCK_COLS  = 3'd5,
    CFG_CROP_ROWS   = 3'd6,
    CFG_CROP_COLS   = 3'd7
  } cfg_idx_t;

  function automatic logic [B2S_NB_W-1:0] clamp_batches(input logic [B2S_NB_W-1:0] v);
    logic [B2S_NB_W-1:0] res;
    res = v;
    if (v == '0) res = B2S_NB_W'(1);
    else if (v > B2S_NB_W'(256)) res = B2S_NB_W'(256);
    return res;
  endfunction

  function automatic logic [B2S_DIM_W-1:0] clamp_dim(input logic [B2S_DIM_W-1:0] v);
    logic [B2S_DIM_W-1:0] res;
    res = v;
    if (v > B2S_DIM_W'(4096)) res = B2S_DIM_W'(4096);
    return res;
  endfunction

  function automatic logic [B2S_BLK_W-1:0] clamp_blk(input logic [B2S_BLK_W-1:0] v);
    logic [B2S_BLK_W-1:0] res;
    res = v;
    if (v == '0) res = B2S_BLK_W'(1);
    else if (v > B2S_BLK_W'(16)) res = B2S_BLK_W'(16);
    return res;
  endfunction

endpackage

>>> design/batch_to_space_address_map_top.sv
// Batch-to-space address map: input position to output position and offset.
// Throughput: one request per cycle; the pipeline halts as a whole while the
// output register holds a stalled result.
// Reset: synchronous active-low rst_n empties the pipeline and restores the configuration registers.
// Depends on b2s_pkg and b2s_div.
module batch_to_space_address_map_top
  import b2s_pkg::*;
#(
  parameter int DIV_STAGES = B2S_DIV_STAGES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [B2S_SRC_BATCH_W-1:0] in_src_batch,
  input  logic [B2S_SRC_ROW_W-1:0]   in_src_row,
  input  logic [B2S_SRC_COL_W-1:0]   in_src_col,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_keep,
  output logic [B2S_DST_BATCH_W-1:0] out_dst_batch,
  output logic [B2S_DST_ROW_W-1:0]   out_dst_row,
  output logic [B2S_DST_COL_W-1:0]   out_dst_col,
  output logic [B2S_OFFSET_W-1:0]    out_dst_offset,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [B2S_CFG_IDX_W-1:0]   cfg_index,
  input  logic [B2S_CFG_DATA_W-1:0]  cfg_data
);

  // input reg, divider stages, then six arithmetic stages ending at the output reg
  localparam int NSTG = DIV_STAGES + 7;

  // ---------------- configuration ----------------
  logic [B2S_NB_W-1:0]   cfg_batches_r;
  logic [B2S_DIM_W-1:0]  cfg_height_r, cfg_width_r, cfg_chan_r;
  logic [B2S_BLK_W-1:0]  cfg_brows_r, cfg_bcols_r;
  logic [B2S_CROP_W-1:0] cfg_crow_r, cfg_ccol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_batches_r <= B2S_NB_W'(1);
      cfg_height_r  <= B2S_DIM_W'(1);
      cfg_width_r   <= B2S_DIM_W'(1);
      cfg_chan_r    <= B2S_DIM_W'(1);
      cfg_brows_r   <= B2S_BLK_W'(1);
      cfg_bcols_r   <= B2S_BLK_W'(1);
      cfg_crow_r    <= '0;
      cfg_ccol_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OUT_BATCHES: cfg_batches_r <= cfg_data[B2S_NB_W-1:0];
        CFG_OUT_HEIGHT:  cfg_height_r  <= cfg_data[B2S_DIM_W-1:0];
        CFG_OUT_WIDTH:   cfg_width_r   <= cfg_data[B2S_DIM_W-1:0];
        CFG_CHANNELS:    cfg_chan_r    <= cfg_data[B2S_DIM_W-1:0];
        CFG_BLOCK_ROWS:  cfg_brows_r   <= cfg_data[B2S_BLK_W-1:0];
        CFG_BLOCK_COLS:  cfg_bcols_r   <= cfg_data[B2S_BLK_W-1:0];
        CFG_CROP_ROWS:   cfg_crow_r    <= cfg_data[B2S_CROP_W-1:0];
        CFG_CROP_COLS:   cfg_ccol_r    <= cfg_data[B2S_CROP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped working copies, registered from the configuration registers
  logic [B2S_NB_W-1:0]   nb_r, nb_nxt;
  logic [B2S_DIM_W-1:0]  oh_r, ow_r, ch_r;
  logic [B2S_BLK_W-1:0]  br_r, bc_r, bc_nxt;
  logic [B2S_NBBC_W-1:0] nbbc_r;

  assign nb_nxt = clamp_batches(cfg_batches_r);
  assign bc_nxt = clamp_blk(cfg_bcols_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r   <= B2S_NB_W'(1);
      oh_r   <= B2S_DIM_W'(1);
      ow_r   <= B2S_DIM_W'(1);
      ch_r   <= B2S_DIM_W'(1);
      br_r   <= B2S_BLK_W'(1);
      bc_r   <= B2S_BLK_W'(1);
      nbbc_r <= B2S_NBBC_W'(1);
    end else begin
      nb_r   <= nb_nxt;
      oh_r   <= clamp_dim(cfg_height_r);
      ow_r   <= clamp_dim(cfg_width_r);
      ch_r   <= clamp_dim(cfg_chan_r);
      br_r   <= clamp_blk(cfg_brows_r);
      bc_r   <= bc_nxt;
      nbbc_r <= B2S_NBBC_W'(nb_nxt * bc_nxt);
    end
  end

  // ---------------- pipeline control ----------------
  logic [NSTG-1:0] vld_r;
  logic            en;

  assign en       = !(vld_r[NSTG-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // ---------------- P0: input register ----------------
  logic [B2S_SRC_BATCH_W-1:0] b0_r;
  logic [B2S_SRC_ROW_W-1:0]   r0_r;
  logic [B2S_SRC_COL_W-1:0]   c0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b0_r <= in_src_batch;
      r0_r <= in_src_row;
      c0_r <= in_src_col;
    end
  end

  // ---------------- divider stages ----------------
  // q = b / nb, db = b % nb, qq = b / (nb * bc) = q / bc
  logic [B2S_SRC_BATCH_W-1:0] q_div, qq_div;
  logic [B2S_NB_W-1:0]        db_div;

  b2s_div #(.NW(B2S_SRC_BATCH_W), .DW(B2S_NB_W), .STAGES(DIV_STAGES)) u_div_nb (
    .clk   (clk),
    .en    (en),
    .num_i (b0_r),
    .den_i (nb_r),
    .quo_o (q_div),
    .rem_o (db_div)
  );

  b2s_div #(.NW(B2S_SRC_BATCH_W), .DW(B2S_NBBC_W), .STAGES(DIV_STAGES)) u_div_blk (
    .clk   (clk),
    .en    (en),
    .num_i (b0_r),
    .den_i (nbbc_r),
    .quo_o (qq_div),
    .rem_o ()
  );

  logic [B2S_SRC_ROW_W-1:0] rd_r [DIV_STAGES];
  logic [B2S_SRC_COL_W-1:0] cd_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r[0] <= r0_r;
      cd_r[0] <= c0_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        rd_r[k] <= rd_r[k-1];
        cd_r[k] <= cd_r[k-1];
      end
    end
  end

  // ---------------- P5: scale and block products ----------------
  logic [16:0]                 rs5_r, cm5_r;
  logic [20:0]                 bq5_r;
  logic [B2S_SRC_BATCH_W-1:0]  q5_r;
  logic [B2S_DST_BATCH_W-1:0]  db5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rs5_r <= 17'(rd_r[DIV_STAGES-1] * br_r) + 17'(qq_div);
      cm5_r <= 17'(cd_r[DIV_STAGES-1] * bc_r);
      bq5_r <= 21'(qq_div * bc_r);
      q5_r  <= q_div;
      db5_r <= db_div[B2S_DST_BATCH_W-1:0];
    end
  end

  // ---------------- P6: row crop and column block offset ----------------
  logic [17:0]                row_d;
  logic [3:0]                 coff_nxt;
  logic                       rok6_r;
  logic [B2S_DST_ROW_W-1:0]   dr6_r;
  logic [16:0]                cm6_r;
  logic [3:0]                 coff6_r;
  logic [B2S_DST_BATCH_W-1:0] db6_r;

  assign row_d    = {1'b0, rs5_r} - 18'(cfg_crow_r);
  // q - bc * (q / bc) is q mod bc, below 16
  assign coff_nxt = 4'(21'(q5_r) - bq5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      rok6_r  <= !row_d[17] && (row_d[16:0] < 17'(oh_r));
      dr6_r   <= row_d[B2S_DST_ROW_W-1:0];
      cm6_r   <= cm5_r;
      coff6_r <= coff_nxt;
      db6_r   <= db5_r;
    end
  end

  // ---------------- P7: column crop and keep ----------------
  logic [17:0]                col_d;
  logic                       keep_nxt;
  logic                       keep7_r;
  logic [B2S_DST_ROW_W-1:0]   dr7_r;
  logic [B2S_DST_COL_W-1:0]   dc7_r;
  logic [B2S_DST_BATCH_W-1:0] db7_r;

  assign col_d    = {1'b0, cm6_r} + 18'(coff6_r) - 18'(cfg_ccol_r);
  assign keep_nxt = rok6_r && !col_d[17] && (col_d[16:0] < 17'(ow_r));

  always_ff @(posedge clk) begin
    if (en) begin
      keep7_r <= keep_nxt;
      dr7_r   <= keep_nxt ? dr6_r : '0;
      dc7_r   <= keep_nxt ? col_d[B2S_DST_COL_W-1:0] : '0;
      db7_r   <= db6_r;
    end
  end

  // ---------------- P8..P10: linear offset ----------------
  logic [19:0]                t8_r;
  logic                       keep8_r, keep9_r;
  logic [B2S_DST_ROW_W-1:0]   dr8_r, dr9_r;
  logic [B2S_DST_COL_W-1:0]   dc8_r, dc9_r;
  logic [B2S_DST_BATCH_W-1:0] db8_r, db9_r;
  logic [31:0]                t9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t8_r    <= 20'(db7_r * oh_r) + 20'(dr7_r);
      keep8_r <= keep7_r;
      dr8_r   <= dr7_r;
      dc8_r   <= dc7_r;
      db8_r   <= db7_r;

      t9_r    <= 32'(t8_r * ow_r) + 32'(dc8_r);
      keep9_r <= keep8_r;
      dr9_r   <= dr8_r;
      dc9_r   <= dc8_r;
      db9_r   <= db8_r;

      out_dst_offset <= keep9_r ? B2S_OFFSET_W'(t9_r * ch_r) : '0;
      out_keep       <= keep9_r;
      out_dst_row    <= dr9_r;
      out_dst_col    <= dc9_r;
      out_dst_batch  <= db9_r;
    end
  end

  assign out_valid = vld_r[NSTG-1];

`ifndef ASSERT_OFF
  a_cropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_keep |->
      (out_dst_row == '0) && (out_dst_col == '0) && (out_dst_offset == '0))
    else $error("cropped position carries nonzero row, column or offset");

  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a halt");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> design/b2s_div.sv
// Pipelined restoring divider: NW/STAGES quotient bits per register stage.
// Uses b2s_pkg for default widths; divisor must be nonzero and held steady.
module b2s_div
  import b2s_pkg::*;
#(
  parameter int NW     = B2S_SRC_BATCH_W,
  parameter int DW     = B2S_NB_W,
  parameter int STAGES = B2S_DIV_STAGES
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int BPS = NW / STAGES;

  logic [DW-1:0] rem_r [STAGES];
  logic [NW-1:0] num_r [STAGES];
  logic [NW-1:0] quo_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] num_nxt;
    logic [NW-1:0] quo_nxt;
    logic [DW:0]   trial;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      num_nxt = num_in;
      quo_nxt = quo_in;
      trial   = '0;
      for (int i = 0; i < BPS; i++) begin
        trial   = {rem_nxt, num_nxt[NW-1]};
        num_nxt = {num_nxt[NW-2:0], 1'b0};
        if (trial >= {1'b0, den_i}) begin
          rem_nxt = DW'(trial - {1'b0, den_i});
          quo_nxt = {quo_nxt[NW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          quo_nxt = {quo_nxt[NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        num_r[s] <= num_nxt;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[STAGES-1];
  assign rem_o = rem_r[STAGES-1];

endmodule

>>> verif/tb_batch_to_space_address_map_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for batch_to_space_address_map_top: directed and random
// requests and stalls, results checked in order. Depends on b2s_pkg.
module tb_batch_to_space_address_map_top
  import b2s_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 16;

  typedef struct packed {
    logic [B2S_SRC_BATCH_W-1:0] batch;
    logic [B2S_SRC_ROW_W-1:0]   row;
    logic [B2S_SRC_COL_W-1:0]   col;
  } src_pos_t;

  typedef struct packed {
    logic                       keep;
    logic [B2S_DST_BATCH_W-1:0] batch;
    logic [B2S_DST_ROW_W-1:0]   row;
    logic [B2S_DST_COL_W-1:0]   col;
    logic [B2S_OFFSET_W-1:0]    offset;
  } dst_pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [B2S_SRC_BATCH_W-1:0] in_src_batch = '0;
  logic [B2S_SRC_ROW_W-1:0]   in_src_row = '0;
  logic [B2S_SRC_COL_W-1:0]   in_src_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_keep;
  logic [B2S_DST_BATCH_W-1:0] out_dst_batch;
  logic [B2S_DST_ROW_W-1:0]   out_dst_row;
  logic [B2S_DST_COL_W-1:0]   out_dst_col;
  logic [B2S_OFFSET_W-1:0]    out_dst_offset;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [B2S_CFG_IDX_W-1:0]  cfg_index = '0;
  logic [B2S_CFG_DATA_W-1:0] cfg_data = '0;

  batch_to_space_address_map_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register mirror, raw as written and clamped for use
  logic [B2S_NB_W-1:0]   raw_nb = 9'd1;
  logic [B2S_DIM_W-1:0]  raw_oh = 13'd1, raw_ow = 13'd1, raw_ch = 13'd1;
  logic [B2S_BLK_W-1:0]  raw_br = 5'd1, raw_bc = 5'd1;
  logic [B2S_CROP_W-1:0] raw_crop_r = '0, raw_crop_c = '0;
  int unsigned eff_nb = 1, eff_oh = 1, eff_ow = 1, eff_ch = 1, eff_br = 1, eff_bc = 1;

  logic [B2S_CFG_DATA_W-1:0] cfg_plan [8];

  src_pos_t pos_pending[$];
  dst_pos_t map_expected[$];
  int  mismatch_cnt = 0;
  int  cycle_cnt = 0;
  bit  src_taken = 1'b0;
  bit  quiet = 1'b0;
  int  in_gap = 0;
  int  stall_left = 0;

  function automatic dst_pos_t map_position(logic [B2S_SRC_BATCH_W-1:0] b,
                                            logic [B2S_SRC_ROW_W-1:0] r,
                                            logic [B2S_SRC_COL_W-1:0] c);
    longint unsigned db, q, off;
    longint row, col;
    dst_pos_t res;
    db = b % eff_nb;
    q = b / eff_nb;
    row = longint'(r * longint'(eff_br) + q / eff_bc) - longint'(raw_crop_r);
    col = longint'(c * longint'(eff_bc) + q % eff_bc) - longint'(raw_crop_c);
    res = '0;
    res.batch = db[B2S_DST_BATCH_W-1:0];
    if (row >= 0 && row < longint'(eff_oh) && col >= 0 && col < longint'(eff_ow)) begin
      res.keep = 1'b1;
      res.row = row[B2S_DST_ROW_W-1:0];
      res.col = col[B2S_DST_COL_W-1:0];
      off = ((db * eff_oh + longint'(row)) * eff_ow + longint'(col)) * eff_ch;
      res.offset = off[B2S_OFFSET_W-1:0];
    end
    return res;
  endfunction

  task automatic mirror_write(cfg_idx_t idx, logic [B2S_CFG_DATA_W-1:0] d);
    case (idx)
      CFG_OUT_BATCHES: raw_nb = d[B2S_NB_W-1:0];
      CFG_OUT_HEIGHT:  raw_oh = d;
      CFG_OUT_WIDTH:   raw_ow = d;
      CFG_CHANNELS:    raw_ch = d;
      CFG_BLOCK_ROWS:  raw_br = d[B2S_BLK_W-1:0];
      CFG_BLOCK_COLS:  raw_bc = d[B2S_BLK_W-1:0];
      CFG_CROP_ROWS:   raw_crop_r = d[B2S_CROP_W-1:0];
      CFG_CROP_COLS:   raw_crop_c = d[B2S_CROP_W-1:0];
      default: ;
    endcase
    eff_nb = (raw_nb == 0) ? 1 : (raw_nb > 256) ? 256 : raw_nb;
    eff_oh = (raw_oh > 4096) ? 4096 : raw_oh;
    eff_ow = (raw_ow > 4096) ? 4096 : raw_ow;
    eff_ch = (raw_ch > 4096) ? 4096 : raw_ch;
    eff_br = (raw_br == 0) ? 1 : (raw_br > 16) ? 16 : raw_br;
    eff_bc = (raw_bc == 0) ? 1 : (raw_bc > 16) ? 16 : raw_bc;
  endtask

  // writes every register from cfg_plan; valid stays up across the burst
  task automatic load_config();
    cfg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_t'(i);
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= cfg_plan[i];
      do @(posedge clk); while (!cfg_ready);
      mirror_write(idx, cfg_plan[i]);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_plan();
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 7) == 0) cfg_plan[i] = 13'($urandom);
      else begin
        case (cfg_idx_t'(i))
          CFG_OUT_BATCHES: cfg_plan[i] = 13'($urandom_range(1, 12));
          CFG_OUT_HEIGHT,
          CFG_OUT_WIDTH:   cfg_plan[i] = 13'($urandom_range(1, 80));
          CFG_CHANNELS:    cfg_plan[i] = 13'($urandom_range(0, 4096));
          CFG_BLOCK_ROWS,
          CFG_BLOCK_COLS:  cfg_plan[i] = 13'($urandom_range(1, 16));
          default:         cfg_plan[i] = 13'($urandom_range(0, 12));
        endcase
      end
    end
  endtask

  task automatic push_pos(int unsigned b, int unsigned r, int unsigned c);
    src_pos_t p;
    p.batch = b[B2S_SRC_BATCH_W-1:0];
    p.row = r[B2S_SRC_ROW_W-1:0];
    p.col = c[B2S_SRC_COL_W-1:0];
    pos_pending.push_back(p);
  endtask

  // mostly positions aimed near the output window, some raw noise
  task automatic push_random_pos();
    int unsigned q, b, er, ec, roff, coff, r, c;
    if ($urandom_range(0, 9) < 3) begin
      push_pos($urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      q = $urandom_range(0, eff_br * eff_bc - 1);
      b = q * eff_nb + $urandom_range(0, eff_nb - 1);
      roff = q / eff_bc;
      coff = q % eff_bc;
      er = $urandom_range(0, eff_oh + raw_crop_r);
      ec = $urandom_range(0, eff_ow + raw_crop_c);
      r = (er >= roff) ? (er - roff) / eff_br : 0;
      c = (ec >= coff) ? (ec - coff) / eff_bc : 0;
      if (r > 4095) r = $urandom_range(0, 4095);
      if (c > 4095) c = $urandom_range(0, 4095);
      push_pos(b, r, c);
    end
  endtask

  task automatic drain();
    while (pos_pending.size() != 0 || map_expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !src_taken)) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 7) - 1;
        in_valid <= 1'b0;
      end else if (pos_pending.size() != 0) begin
        in_valid <= 1'b1;
        in_src_batch <= pos_pending[0].batch;
        in_src_row <= pos_pending[0].row;
        in_src_col <= pos_pending[0].col;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic flag_field(string name, logic [B2S_OFFSET_W-1:0] want,
                            logic [B2S_OFFSET_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // monitor: predict on request accept, check on result accept
  always @(posedge clk) begin
    dst_pos_t want;
    cycle_cnt <= cycle_cnt + 1;
    src_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        map_expected.push_back(map_position(in_src_batch, in_src_row, in_src_col));
        void'(pos_pending.pop_front());
        src_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (map_expected.size() == 0) begin
          $display("%0t: unexpected result keep=%b batch=%h row=%h col=%h offset=%h",
                   $time, out_keep, out_dst_batch, out_dst_row, out_dst_col, out_dst_offset);
          mismatch_cnt++;
        end else begin
          want = map_expected.pop_front();
          flag_field("keep", want.keep, out_keep);
          flag_field("dst_batch", want.batch, out_dst_batch);
          flag_field("dst_row", want.row, out_dst_row);
          flag_field("dst_col", want.col, out_dst_col);
          flag_field("dst_offset", want.offset, out_dst_offset);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("batch_to_space_address_map_top: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one kept, one cropped column, one cropped by quotient
    push_pos(0, 0, 0);
    push_pos(0, 0, 1);
    push_pos(1, 0, 0);
    drain();

    cfg_plan = '{13'd3, 13'd8, 13'd9, 13'd5, 13'd2, 13'd3, 13'd1, 13'd2};
    load_config();
    push_pos(0, 0, 0);           // cropped at the top-left corner
    push_pos(5, 1, 1);           // kept, nonzero quotient
    push_pos(17, 2, 2);          // largest in-range quotient
    push_pos(19, 1, 1);          // quotient past the block count
    push_pos(5, 4, 3);           // last kept row and column
    push_pos(9, 4, 3);           // one row past the bottom
    push_pos(3, 4, 4);           // three columns past the right
    push_pos(65535, 4095, 4095);
    push_pos(65535, 0, 0);
    push_pos(0, 4095, 0);
    push_pos(0, 0, 4095);
    push_pos(2, 1, 1);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: cfg_plan = '{13'd256, 13'd4096, 13'd4096, 13'd4096, 13'd16, 13'd16,
                        13'd255, 13'd255};
        1: cfg_plan = '{default: 13'h1FFF};
        2: cfg_plan = '{default: 13'd0};
        default: random_plan();
      endcase
      load_config();
      if (ph == 8) quiet = 1'b1;
      for (int i = 0; i < 76; i++) push_random_pos();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) $display("batch_to_space_address_map_top: match");
    else $display("batch_to_space_address_map_top: mismatch");
    $finish;
  end

endmodule
